/* design/lpc_pkg.sv */
package lpc_pkg;

	localparam int unsigned GEN_W = 128;
	localparam int unsigned HALF_W = 64;
	localparam int unsigned CNT_W = 32;

	// Width mode codes. The reserved code behaves as the 32-bit mode.
	localparam logic [1:0] MODE_32 = 2'd0;
	localparam logic [1:0] MODE_64 = 2'd1;
	localparam logic [1:0] MODE_128 = 2'd2;
	localparam logic [1:0] MODE_RSVD = 2'd3;

	// Tap masks with the top bit of each width already cleared.
	localparam logic [GEN_W-1:0] TAP_32 = 128'h0000_0000_0000_0000_0000_0000_2300_0000;
	localparam logic [GEN_W-1:0] TAP_64 = 128'h0000_0000_0000_0000_5800_0000_0000_0000;
	localparam logic [GEN_W-1:0] TAP_128 = 128'h6100_0000_0000_0000_0000_0000_0000_0000;

	localparam logic [GEN_W-1:0] MASK_32 = 128'h0000_0000_0000_0000_0000_0000_FFFF_FFFF;
	localparam logic [GEN_W-1:0] MASK_64 = 128'h0000_0000_0000_0000_FFFF_FFFF_FFFF_FFFF;
	localparam logic [GEN_W-1:0] MASK_128 = {GEN_W{1'b1}};

	localparam logic [GEN_W-1:0] TOP_32 = 128'h0000_0000_0000_0000_0000_0000_8000_0000;
	localparam logic [GEN_W-1:0] TOP_64 = 128'h0000_0000_0000_0000_8000_0000_0000_0000;
	localparam logic [GEN_W-1:0] TOP_128 = 128'h8000_0000_0000_0000_0000_0000_0000_0000;

	// Per-cycle control shared by every cell.
	typedef struct packed {
		logic adv;
		logic fb;
		logic fill;
	} lpc_ctl_t;

	// Per-bit setup derived from the width mode.
	typedef struct packed {
		logic mask;
		logic top;
		logic tap;
	} lpc_lane_t;

	function automatic logic [GEN_W-1:0] lpc_width_mask(input logic [1:0] mode);
		logic [GEN_W-1:0] m;
		unique case (mode)
			MODE_64: m = MASK_64;
			MODE_128: m = MASK_128;
			default: m = MASK_32;
		endcase
		return m;
	endfunction

	function automatic logic [GEN_W-1:0] lpc_top_mask(input logic [1:0] mode);
		logic [GEN_W-1:0] m;
		unique case (mode)
			MODE_64: m = TOP_64;
			MODE_128: m = TOP_128;
			default: m = TOP_32;
		endcase
		return m;
	endfunction

	function automatic logic [GEN_W-1:0] lpc_tap_mask(input logic [1:0] mode);
		logic [GEN_W-1:0] m;
		unique case (mode)
			MODE_64: m = TAP_64;
			MODE_128: m = TAP_128;
			default: m = TAP_32;
		endcase
		return m;
	endfunction

endpackage

/* design/lfsr_pattern_checker.sv */
// A word accepted at one clock edge has its result registered and valid after that edge.
// Throughput: one word per cycle; the next word is taken while a result waits, as long as
// the output register is empty or is being drained in the same cycle.
// Reset (arst_n low, asynchronous) clears the generator, which then reads as all ones,
// the word counter, the width mode (32 bits) and the output valid flag.
module lfsr_pattern_checker
	import lpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  width_mode,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] data_low,
	input  logic [63:0] data_high,

	output logic        out_valid,
	input  logic        out_ready,
	output logic        mismatch,
	output logic [31:0] word_number,
	output logic [63:0] expected_low,
	output logic [63:0] expected_high,
	output logic [63:0] difference_low,
	output logic [63:0] difference_high
);

	// The width mode register. Writes must arrive only while the block is idle;
	// the block itself does not enforce this, and the port is always ready.
	logic [1:0] mode_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_32;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= width_mode;
		end
	end

	// Per-bit setup of the cell row for the current mode: which bits lie
	// inside the width, which bit is the top of the width, and the taps.
	logic [GEN_W-1:0] mask_v;
	logic [GEN_W-1:0] top_v;
	logic [GEN_W-1:0] tap_v;
	lpc_lane_t        lane_v [GEN_W];

	assign mask_v = lpc_width_mask(mode_q);
	assign top_v = lpc_top_mask(mode_q);
	assign tap_v = lpc_tap_mask(mode_q);

	always_comb begin
		for (int i = 0; i < GEN_W; i++) begin
			lane_v[i] = '{mask: mask_v[i], top: top_v[i], tap: tap_v[i]};
		end
	end

	// A word is taken whenever the output register is free or being emptied.
	logic     out_valid_q;
	logic     adv;
	lpc_ctl_t ctl;

	assign in_ready = !out_valid_q || out_ready;
	assign adv = in_valid && in_ready;

	// The row of cells. Each cell holds one generator bit, compares it with
	// its data bit, and on every accepted word takes the expected bit of its
	// upper neighbor, which makes the row one Galois shift register.
	logic [GEN_W-1:0] data_v;
	logic [GEN_W-1:0] gen_m_v;
	logic [GEN_W-1:0] exp_v;
	logic [GEN_W-1:0] diff_v;

	assign data_v = {data_high, data_low};

	// When the generator is zero within the width it reads as all ones, and
	// the feedback bit is the low bit of what is actually expected. Bit 0 is
	// inside every width, so that bit is one whenever the fill applies.
	assign ctl.adv = adv;
	assign ctl.fill = ~|gen_m_v;
	assign ctl.fb = (~|gen_m_v) | gen_m_v[0];

	for (genvar g = 0; g < GEN_W; g++) begin : g_cell
		logic nb;
		if (g == GEN_W - 1) begin : g_last
			assign nb = 1'b0;
		end else begin : g_mid
			assign nb = exp_v[g+1];
		end

		lpc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.lane     (lane_v[g]),
			.data_bit (data_v[g]),
			.nb_exp   (nb),
			.gen_m    (gen_m_v[g]),
			.exp_bit  (exp_v[g]),
			.diff_bit (diff_v[g])
		);
	end

	// Running word count; the result carries the count including this word.
	logic [CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				cnt_q <= cnt_q + CNT_W'(1);
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output register for the result word. It loads on every accepted word.
	logic             mismatch_q;
	logic [CNT_W-1:0] word_number_q;
	logic [GEN_W-1:0] expected_q;
	logic [GEN_W-1:0] difference_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			mismatch_q <= |diff_v;
			word_number_q <= cnt_q + CNT_W'(1);
			expected_q <= exp_v;
			difference_q <= diff_v;
		end
	end

	assign out_valid = out_valid_q;
	assign mismatch = mismatch_q;
	assign word_number = word_number_q;
	assign expected_low = expected_q[HALF_W-1:0];
	assign expected_high = expected_q[GEN_W-1:HALF_W];
	assign difference_low = difference_q[HALF_W-1:0];
	assign difference_high = difference_q[GEN_W-1:HALF_W];

endmodule

/* design/lpc_cell.sv */
module lpc_cell
	import lpc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  lpc_ctl_t  ctl,
	input  lpc_lane_t lane,
	input  logic      data_bit,
	input  logic      nb_exp,
	output logic      gen_m,
	output logic      exp_bit,
	output logic      diff_bit
);

	logic gen_q;
	logic nxt;

	// The stored bit within the width; a zero generator reads as all ones.
	assign gen_m = gen_q & lane.mask;
	assign exp_bit = ctl.fill ? lane.mask : gen_m;
	assign diff_bit = (data_bit & lane.mask) ^ exp_bit;

	// Width top takes the low bit; others the upper neighbor, XORed with it at taps.
	assign nxt = (lane.top ? ctl.fb : nb_exp) ^ (ctl.fb & lane.tap);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q <= 1'b0;
		end else if (ctl.adv) begin
			gen_q <= nxt;
		end
	end

endmodule

/* design/lpc_checker.sv */
module lpc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [1:0]  width_mode,
	input logic        in_valid,
	input logic        in_ready,
	input logic [63:0] data_low,
	input logic [63:0] data_high,
	input logic        out_valid,
	input logic        out_ready,
	input logic        mismatch,
	input logic [31:0] word_number,
	input logic [63:0] expected_low,
	input logic [63:0] expected_high,
	input logic [63:0] difference_low,
	input logic [63:0] difference_high
);

	// A stalled result keeps its word number.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(word_number))
		else $error("result word changed while stalled");

	// Every accepted word shows up as a result in the next cycle.
	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted word produced no result");

	// The mismatch flag agrees with the reported difference.
	a_mismatch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (mismatch == ((difference_low != 64'd0) || (difference_high != 64'd0))))
		else $error("mismatch flag disagrees with difference");

	// An empty output register never holds back the input side.
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

endmodule

bind lfsr_pattern_checker lpc_checker u_lpc_checker (.*);
